@@ design/spp_pkg.sv @@
// ---------------------------------------------------------------------------
// spp_pkg
// shared codes and types for the sweep and prune pair finder
// ---------------------------------------------------------------------------
`default_nettype none

package spp_pkg;

   // request modes
   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_NEXT  = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_ACCEPT = 2'd0;
   localparam logic [1:0] STAT_PAIR   = 2'd1;
   localparam logic [1:0] STAT_NONE   = 2'd2;
   localparam logic [1:0] STAT_FULL   = 2'd3;

   // box compare results
   typedef struct packed {
      logic pruned;
      logic overlap;
   } cmp_type;

   // controller states
   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SHIFT    = 8'b0000_0010,
      ST_PUT      = 8'b0000_0100,
      ST_SC_START = 8'b0000_1000,
      ST_SC_LOADA = 8'b0001_0000,
      ST_SC_INNER = 8'b0010_0000,
      ST_SC_CHKB  = 8'b0100_0000,
      ST_RESP     = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

@@ design/spp_ram.sv @@
// ---------------------------------------------------------------------------
// spp_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module spp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/spp_box_cmp.sv @@
// ---------------------------------------------------------------------------
// spp_box_cmp
// prune and overlap test of a later box against an earlier box
// ---------------------------------------------------------------------------
`default_nettype none

module spp_box_cmp #(
   parameter int COORD_BITS = 16
) (
   input  wire logic [4*COORD_BITS-1:0] a_box,
   input  wire logic [4*COORD_BITS-1:0] b_box,
   output spp_pkg::cmp_type             result
);
   import spp_pkg::*;

   logic signed [COORD_BITS-1:0] a_min_x, a_min_y, a_max_x, a_max_y;
   logic signed [COORD_BITS-1:0] b_min_x, b_min_y, b_max_x, b_max_y;

   // box layout: {max_y, max_x, min_y, min_x}
   assign a_min_x = $signed(a_box[COORD_BITS-1:0]);
   assign a_min_y = $signed(a_box[2*COORD_BITS-1:COORD_BITS]);
   assign a_max_x = $signed(a_box[3*COORD_BITS-1:2*COORD_BITS]);
   assign a_max_y = $signed(a_box[4*COORD_BITS-1:3*COORD_BITS]);
   assign b_min_x = $signed(b_box[COORD_BITS-1:0]);
   assign b_min_y = $signed(b_box[2*COORD_BITS-1:COORD_BITS]);
   assign b_max_x = $signed(b_box[3*COORD_BITS-1:2*COORD_BITS]);
   assign b_max_y = $signed(b_box[4*COORD_BITS-1:3*COORD_BITS]);

   // inclusive overlap on both axes, prune when b starts past a
   assign result.pruned  = b_min_x > a_max_x;
   assign result.overlap = (a_min_x <= b_max_x) && (b_min_x <= a_max_x) &&
                           (a_min_y <= b_max_y) && (b_min_y <= a_max_y);

endmodule

`default_nettype wire

@@ design/sweep_and_prune_pairs.sv @@
// ---------------------------------------------------------------------------
// sweep_and_prune_pairs
// broadphase pair finder: boxes kept sorted by min x in one ram, pair scan
// resumes from stored cursors on each next request
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    mode, box corners, owner_id
//   rsp      out        rsp_valid/stall    status, first/second entity
//
// clear and unused mode: straight to the response state
// load: one ram read-compare-shift per moved entry, then the write of the
//   new box; no further compare once the box reaches the bottom of the list
// next: per outer box a read of that box, then a read and compare per
//   candidate box, all through the single ram read port
// reset empties the store at once, no clearing pass
// a stalled response holds; a new beat is taken while it waits
// ---------------------------------------------------------------------------
`default_nettype none

module sweep_and_prune_pairs #(
   parameter int MAX_BOXES  = 64,
   parameter int COORD_BITS = 16,
   parameter int ID_BITS    = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_mode,
   input  wire logic signed [COORD_BITS-1:0] req_box_min_x,
   input  wire logic signed [COORD_BITS-1:0] req_box_min_y,
   input  wire logic signed [COORD_BITS-1:0] req_box_max_x,
   input  wire logic signed [COORD_BITS-1:0] req_box_max_y,
   input  wire logic [ID_BITS-1:0]           req_owner_id,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [ID_BITS-1:0]                rsp_first_entity,
   output logic [ID_BITS-1:0]                rsp_second_entity
);
   import spp_pkg::*;

   localparam int AW    = $clog2(MAX_BOXES);
   localparam int CW    = $clog2(MAX_BOXES + 2);
   localparam int BW    = 4 * COORD_BITS;
   localparam int EW    = BW + ID_BITS;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BOXES);
   localparam logic [CW-1:0] ONE     = CW'(1);
   localparam logic [CW-1:0] TWO     = CW'(2);

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     outer_ff, outer_in;
   logic [CW-1:0]     inner_ff, inner_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [EW-1:0]     new_ff, new_in;
   logic [EW-1:0]     a_ff, a_in;
   logic [1:0]        stat_ff, stat_in;
   logic [ID_BITS-1:0] first_ff, first_in, second_ff, second_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [ID_BITS-1:0] rsp_first_ff, rsp_second_ff;

   logic              req_take, out_free, out_load;
   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [EW-1:0]     wr_data, rd_data;
   cmp_type           cmp;

   // entry store: {owner, max_y, max_x, min_y, min_x}
   spp_ram #(.WIDTH(EW), .DEPTH(MAX_BOXES)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   spp_box_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
      .a_box (a_ff[BW-1:0]),
      .b_box (rd_data[BW-1:0]),
      .result(cmp)
   );

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == ST_RESP) && out_free;

   // controller
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      outer_in  = outer_ff;
      inner_in  = inner_ff;
      pos_in    = pos_ff;
      new_in    = new_ff;
      a_in      = a_ff;
      stat_in   = stat_ff;
      first_in  = first_ff;
      second_in = second_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff[AW-1:0];
      wr_data   = new_ff;
      rd_addr   = outer_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            first_in  = '0;
            second_in = '0;
            stat_in   = STAT_ACCEPT;
            if (req_take) begin
               unique case (req_mode)
                  MODE_CLEAR: begin
                     count_in = '0;
                     outer_in = '0;
                     inner_in = ONE;
                     state_in = ST_RESP;
                  end
                  MODE_LOAD: begin
                     new_in = {req_owner_id, req_box_max_y, req_box_max_x,
                               req_box_min_y, req_box_min_x};
                     pos_in = count_ff;
                     if (count_ff >= CNT_MAX) begin
                        stat_in  = STAT_FULL;
                        state_in = ST_RESP;
                     end else if (count_ff == '0) begin
                        state_in = ST_PUT;
                     end else begin
                        rd_addr  = AW'(count_ff - ONE);
                        state_in = ST_SHIFT;
                     end
                  end
                  MODE_NEXT: state_in = ST_SC_START;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_SHIFT: begin
            // rd_data holds the entry just below pos
            if ($signed(rd_data[COORD_BITS-1:0]) >
                $signed(new_ff[COORD_BITS-1:0])) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = pos_ff - ONE;
               if (pos_ff == ONE) begin
                  state_in = ST_PUT;
               end else begin
                  rd_addr = AW'(pos_ff - TWO);
               end
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            wr_en    = 1'b1;
            count_in = count_ff + ONE;
            outer_in = '0;
            inner_in = ONE;
            state_in = ST_RESP;
         end
         ST_SC_START: begin
            rd_addr = outer_ff[AW-1:0];
            if (outer_ff < count_ff) begin
               state_in = ST_SC_LOADA;
            end else begin
               stat_in  = STAT_NONE;
               state_in = ST_RESP;
            end
         end
         ST_SC_LOADA: begin
            a_in     = rd_data;
            state_in = ST_SC_INNER;
         end
         ST_SC_INNER: begin
            rd_addr = inner_ff[AW-1:0];
            if (inner_ff < count_ff) begin
               state_in = ST_SC_CHKB;
            end else begin
               outer_in = outer_ff + ONE;
               inner_in = outer_ff + TWO;
               state_in = ST_SC_START;
            end
         end
         ST_SC_CHKB: begin
            if (cmp.pruned) begin
               outer_in = outer_ff + ONE;
               inner_in = outer_ff + TWO;
               state_in = ST_SC_START;
            end else begin
               inner_in = inner_ff + ONE;
               if (cmp.overlap) begin
                  stat_in   = STAT_PAIR;
                  first_in  = a_ff[EW-1:BW];
                  second_in = rd_data[EW-1:BW];
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_SC_INNER;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         outer_ff     <= '0;
         inner_ff     <= ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         outer_ff <= outer_in;
         inner_ff <= inner_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      new_ff    <= new_in;
      a_ff      <= a_in;
      stat_ff   <= stat_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      if (out_load) begin
         rsp_status_ff <= stat_ff;
         rsp_first_ff  <= first_ff;
         rsp_second_ff <= second_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_first_entity  = rsp_first_ff;
   assign rsp_second_entity = rsp_second_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("stored count above capacity");

   a_outer_bound: assert property (@(posedge clock) disable iff (reset)
      outer_ff <= count_ff)
      else $error("outer cursor past stored count");

   a_inner_order: assert property (@(posedge clock) disable iff (reset)
      inner_ff > outer_ff)
      else $error("inner cursor not after outer cursor");

   a_ids_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_PAIR) |->
         (rsp_first_ff == '0 && rsp_second_ff == '0))
      else $error("entity ids set without a pair");

   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      out_load |=> state_ff == ST_IDLE)
      else $error("response state did not return to idle");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// sweep_and_prune_pairs testbench
// drives clear, load, next and unused mode beats in random bursts against a random
// response stall, predicts each response with a sorted box list and scan
// cursors of its own, and compares status and pair entities in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected responses and the predicted store behind them
class pair_scoreboard;
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] first_ent;
      logic [7:0] second_ent;
   } rsp_beat_type;

   logic signed [15:0] lo_x[64], lo_y[64], hi_x[64], hi_y[64];
   logic [7:0]         owner[64];
   int                 count;
   int                 outer_i;
   int                 inner_i;
   rsp_beat_type       pending[$];
   int                 errors;

   function void restart();
      outer_i = 0;
      inner_i = 1;
   endfunction

   function void clear_all();
      count = 0;
      errors = 0;
      restart();
   endfunction

   function bit touches(int a, int b);
      return lo_x[a] <= hi_x[b] && lo_x[b] <= hi_x[a] &&
             lo_y[a] <= hi_y[b] && lo_y[b] <= hi_y[a];
   endfunction

   // note an accepted request beat
   function void note_request(logic [1:0] mode, logic signed [15:0] mnx,
                              logic signed [15:0] mny, logic signed [15:0] mxx,
                              logic signed [15:0] mxy, logic [7:0] id);
      rsp_beat_type r;
      int        pos;
      bit        found;
      r = '0;
      r.status = spp_pkg::STAT_ACCEPT;
      if (mode == spp_pkg::MODE_CLEAR) begin
         count = 0;
         restart();
      end else if (mode == spp_pkg::MODE_LOAD) begin
         if (count >= 64) begin
            r.status = spp_pkg::STAT_FULL;
         end else begin
            pos = count;
            while (pos > 0 && lo_x[pos-1] > mnx) begin
               lo_x[pos] = lo_x[pos-1]; lo_y[pos] = lo_y[pos-1];
               hi_x[pos] = hi_x[pos-1]; hi_y[pos] = hi_y[pos-1];
               owner[pos] = owner[pos-1];
               pos--;
            end
            lo_x[pos] = mnx; lo_y[pos] = mny; hi_x[pos] = mxx; hi_y[pos] = mxy;
            owner[pos] = id;
            count++;
            restart();
         end
      end else if (mode == spp_pkg::MODE_NEXT) begin
         found = 0;
         while (!found && outer_i < count) begin
            while (inner_i < count) begin
               if (lo_x[inner_i] > hi_x[outer_i]) break;
               inner_i++;
               if (touches(outer_i, inner_i - 1)) begin
                  found = 1;
                  r.first_ent = owner[outer_i];
                  r.second_ent = owner[inner_i - 1];
                  break;
               end
            end
            if (!found) begin
               outer_i++;
               inner_i = outer_i + 1;
            end
         end
         r.status = found ? spp_pkg::STAT_PAIR : spp_pkg::STAT_NONE;
      end
      pending.insert(pending.size(), r);
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   // compare one accepted response with the oldest expectation
   task check_response(logic [1:0] st, logic [7:0] f, logic [7:0] s);
      rsp_beat_type e;
      if (pending.size() == 0) begin
         report($sformatf("unexpected response status %0d", st));
      end else begin
         e = pending.pop_front();
         if (st !== e.status)
            report($sformatf("status got %0d want %0d", st, e.status));
         if (f !== e.first_ent)
            report($sformatf("first entity got %0d want %0d", f, e.first_ent));
         if (s !== e.second_ent)
            report($sformatf("second entity got %0d want %0d", s, e.second_ent));
      end
   endtask
endclass

module testbench;
   import spp_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic [1:0]        req_mode = MODE_CLEAR;
   logic signed [15:0] req_box_min_x = 0, req_box_min_y = 0;
   logic signed [15:0] req_box_max_x = 0, req_box_max_y = 0;
   logic [7:0]        req_owner_id = 0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic [1:0]        rsp_status;
   logic [7:0]        rsp_first_entity, rsp_second_entity;

   pair_scoreboard    board;
   longint            cycles = 0;
   int                stall_mode = 0;
   bit                sending_done = 0;

   sweep_and_prune_pairs dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_box_min_x(req_box_min_x), .req_box_min_y(req_box_min_y),
      .req_box_max_x(req_box_max_x), .req_box_max_y(req_box_max_y),
      .req_owner_id(req_owner_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_first_entity(rsp_first_entity), .rsp_second_entity(rsp_second_entity)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("sweep_and_prune_pairs verification failed");
         $finish;
      end
   end

   // response side: check beats, stall on a shifting pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_status, rsp_first_entity, rsp_second_entity);
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // send one request beat and wait for its acceptance
   task send_beat(logic [1:0] m, logic signed [15:0] a, logic signed [15:0] b,
                  logic signed [15:0] c, logic signed [15:0] d, logic [7:0] id);
      req_valid <= 1;
      req_mode <= m;
      req_box_min_x <= a; req_box_min_y <= b;
      req_box_max_x <= c; req_box_max_y <= d;
      req_owner_id <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(m, a, b, c, d, id);
   endtask

   task idle_gap(int n);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // random box in a window so that overlaps are common
   task load_random(int span);
      logic signed [15:0] x, y;
      x = $signed(16'($urandom_range(0, span))) - 16'(span / 2);
      y = $signed(16'($urandom_range(0, span))) - 16'(span / 2);
      send_beat(MODE_LOAD, x, y, x + 16'($urandom_range(0, span / 4)),
                y + 16'($urandom_range(0, span / 4)), 8'($urandom));
   endtask

   initial begin
      int n, k, burst;
      board = new();
      board.clear_all();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, ties, inverted box, unused mode, full store
      send_beat(MODE_NEXT, 0, 0, 0, 0, 0);
      send_beat(MODE_LOAD, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 8'hff);
      send_beat(MODE_LOAD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'h00);
      send_beat(MODE_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 8'h55);
      send_beat(MODE_LOAD, 16'sh8000, 16'sh0010, 16'sh8000, 16'sh0010, 8'haa);
      send_beat(MODE_LOAD, 16'sh0020, 16'sh0020, 16'sh0010, 16'sh0010, 8'h11);
      send_beat(2'd3, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 8'hff);
      repeat (8) send_beat(MODE_NEXT, 0, 0, 0, 0, 0);
      send_beat(MODE_CLEAR, 0, 0, 0, 0, 0);
      send_beat(MODE_NEXT, 0, 0, 0, 0, 0);
      for (k = 0; k < 66; k++)
         send_beat(MODE_LOAD, 16'(k), 0, 16'(k + 1), 0, 8'(k));
      repeat (4) send_beat(MODE_NEXT, 0, 0, 0, 0, 0);

      // random: sessions of clear, loads, then a run of next and unused mode requests
      n = 0;
      while (n < 1350) begin
         send_beat(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom));
         n++;
         burst = ($urandom_range(0, 15) == 0) ? 64 : $urandom_range(1, 14);
         for (k = 0; k < burst; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(MODE_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 8'($urandom));
            else
               load_random($urandom_range(0, 1) ? 64 : 4096);
            n++;
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 6));
         end
         burst = $urandom_range(1, 20);
         for (k = 0; k < burst; k++) begin
            if ($urandom_range(0, 11) == 0)
               send_beat(2'd3, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 8'($urandom));
            else
               send_beat(MODE_NEXT, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 8'($urandom));
            n++;
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 9));
         end
      end
      req_valid <= 0;

      // drain, then a short settle
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0)
         $display("sweep_and_prune_pairs verification clean");
      else
         $display("sweep_and_prune_pairs verification failed");
      $finish;
   end
endmodule

@@ sim.f @@
design/spp_pkg.sv
design/spp_ram.sv
design/spp_box_cmp.sv
design/sweep_and_prune_pairs.sv
bench/testbench.sv
